// File: sv/lpht_pkg.sv
// Shared constants, codes and controller/datapath interface structs for the
// linear-probe hash table. No dependencies.
`default_nettype none

package lpht_pkg;

    // Default table size; the top level hands its TABLE_SLOTS down from here.
    localparam int TABLE_SLOTS_DEF = 256;
    // Bytes of the key that count; bytes at or past this are forced to zero.
    localparam int KEY_BYTES = 8;

    localparam int KEY_W       = 64;
    localparam int VAL_W       = 31;
    localparam int STATUS_W    = 2;
    localparam int SLOT_W      = 8;
    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 8;

    // djb2
    localparam logic [31:0] HASH_SEED  = 32'd5381;
    localparam int          HASH_SHIFT = 5;

    // Request kinds
    localparam logic OP_SEARCH = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    // Result codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;

    // Controller -> datapath
    typedef struct packed {
        logic load;      // capture request word
        logic clr_step;  // clear one flag entry
        logic hash_step; // fold one key byte into the hash
        logic mod_step;  // one stage of the remainder
        logic rd;        // read tables at probe position
        logic eval;      // judge the slot just read
        logic emit;      // move result into output register
    } t_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic hash_last;
        logic mod_last;
        logic eval_done;
        logic out_busy;
    } t_sts;

endpackage

`default_nettype wire

// File: sv/lpht_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered
// read data. No dependencies.
`default_nettype none

module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: sv/lpht_ctrl.sv
// Sequencing state machine for the hash table: clear pass, hash, remainder,
// probe loop, result handoff. Depends on lpht_pkg.
`default_nettype none

module lpht_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire lpht_pkg::t_sts  i_sts,
    output lpht_pkg::t_cmd       o_cmd
);
    import lpht_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HASH  = 3'd2;
    localparam logic [2:0] S_MOD   = 3'd3;
    localparam logic [2:0] S_READ  = 3'd4;
    localparam logic [2:0] S_EVAL  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_HASH;
                end
            end
            S_HASH: begin
                o_cmd.hash_step = 1'b1;
                if (i_sts.hash_last) n_state = S_MOD;
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_sts.mod_last) n_state = S_READ;
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = i_sts.eval_done ? S_DONE : S_READ;
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

`default_nettype wire

// File: sv/lpht_dp.sv
// Datapath of the hash table: key cleanup, djb2 hash, remainder unit, probe
// position, flag and key tables, output register. Depends on lpht_pkg, lpht_ram.
`default_nettype none

module lpht_dp #(
    parameter int TABLE_SLOTS = lpht_pkg::TABLE_SLOTS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire lpht_pkg::t_cmd                 i_cmd,
    output lpht_pkg::t_sts                      o_sts,
    input  wire logic                           i_op,
    input  wire logic [lpht_pkg::KEY_W-1:0]     i_key,
    input  wire logic [lpht_pkg::VAL_W-1:0]     i_value,
    input  wire logic                           i_out_ready,
    output logic                                o_out_valid,
    output logic      [lpht_pkg::STATUS_W-1:0]  o_out_status,
    output logic      [lpht_pkg::SLOT_W-1:0]    o_out_slot
);
    import lpht_pkg::*;

    localparam int             AW   = $clog2(TABLE_SLOTS);
    localparam int             DW   = KEY_W + VAL_W;
    localparam logic [AW:0]    NSL  = (AW+1)'(TABLE_SLOTS);
    localparam logic [AW-1:0]  LAST = AW'(TABLE_SLOTS - 1);
    // floor(2^32 / slots): the quotient estimate is exact or one short
    localparam logic [63:0]    RECIP_FULL = (64'd1 << 32) / 64'(TABLE_SLOTS);
    localparam logic [31:0]    RECIP      = RECIP_FULL[31:0];
    localparam logic [31:0]    NSL32      = 32'(TABLE_SLOTS);

    // request
    logic                r_op;
    logic [KEY_W-1:0]    r_key;
    logic [VAL_W-1:0]    r_value;
    // hash / remainder
    logic [31:0]         r_hash;
    logic [2:0]          r_byte;
    logic [31:0]         r_quot;
    logic [AW:0]         r_rem;
    logic [1:0]          r_mcnt;
    // probe
    logic [AW-1:0]       r_pos;
    logic [AW-1:0]       r_probes;
    logic [AW-1:0]       r_clr_addr;
    // result
    logic [STATUS_W-1:0] r_res_status;
    logic [SLOT_W-1:0]   r_res_slot;
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [SLOT_W-1:0]   r_out_slot;

    logic [KEY_W-1:0]    w_clean;
    logic [7:0]          w_byte;
    logic [31:0]         w_hash_next;
    logic [63:0]         w_prod;
    logic [31:0]         w_qn;
    logic [31:0]         w_diff;
    logic [AW:0]         w_rem_fix;
    logic [1:0]          w_flags_rd;
    logic [DW-1:0]       w_data_rd;
    logic                w_valid;
    logic                w_probed;
    logic                w_hit;
    logic                w_probe_last;
    logic [AW-1:0]       w_pos_next;
    logic                w_done;
    logic [STATUS_W-1:0] w_status;
    logic                w_flags_we;
    logic [AW-1:0]       w_flags_waddr;
    logic [1:0]          w_flags_wdata;
    logic                w_data_we;

    // Keep bytes up to the first zero byte, within KEY_BYTES.
    always_comb begin
        logic v_alive;
        v_alive = 1'b1;
        w_clean = '0;
        for (int i = 0; i < 8; i++) begin
            v_alive = v_alive && (i < KEY_BYTES) && (i_key[8*i +: 8] != 8'd0);
            if (v_alive) w_clean[8*i +: 8] = i_key[8*i +: 8];
        end
    end

    // hash = hash*33 + sign-extended byte
    assign w_byte      = r_key[{r_byte, 3'b000} +: 8];
    assign w_hash_next = (r_hash << HASH_SHIFT) + r_hash + {{24{w_byte[7]}}, w_byte};

    // Remainder by TABLE_SLOTS in three steps: quotient estimate by reciprocal
    // multiply, hash minus quotient*slots (below twice the slots), then one
    // conditional subtract.
    assign w_prod    = {32'd0, r_hash} * {32'd0, RECIP};
    assign w_qn      = r_quot * NSL32;
    assign w_diff    = r_hash - w_qn;
    assign w_rem_fix = (r_rem >= NSL) ? r_rem - NSL : r_rem;

    // Probe judgment on the slot read last cycle.
    assign w_valid      = w_flags_rd[1];
    assign w_probed     = w_flags_rd[0];
    assign w_hit        = w_valid && (w_data_rd[KEY_W-1:0] == r_key);
    assign w_probe_last = (r_probes == LAST);
    assign w_pos_next   = (r_pos == LAST) ? '0 : r_pos + 1'b1;

    always_comb begin
        w_done   = 1'b0;
        w_status = ST_FULL;
        if (r_op == OP_INSERT) begin
            if (!w_valid) begin
                w_done   = 1'b1;
                w_status = ST_OK;
            end else if (w_probe_last) begin
                w_done = 1'b1;
            end
        end else begin
            if (w_hit) begin
                w_done   = 1'b1;
                w_status = ST_OK;
            end else if (!w_probed) begin
                w_done   = 1'b1;
                w_status = ST_ABSENT;
            end else if (w_probe_last) begin
                w_done = 1'b1;
            end
        end
    end

    // flags: [1] valid, [0] probed through. Insert sets probed on occupied
    // slots it passes and valid on the free slot it takes.
    assign w_flags_we    = i_cmd.clr_step || (i_cmd.eval && (r_op == OP_INSERT));
    assign w_flags_waddr = i_cmd.clr_step ? r_clr_addr : r_pos;
    assign w_flags_wdata = i_cmd.clr_step ? 2'b00 : (w_valid ? 2'b11 : {1'b1, w_probed});
    assign w_data_we     = i_cmd.eval && (r_op == OP_INSERT) && !w_valid;

    lpht_ram #(
        .WIDTH (2),
        .DEPTH (TABLE_SLOTS)
    ) u_flags (
        .i_clk     (i_clk),
        .i_wr_en   (w_flags_we),
        .i_wr_addr (w_flags_waddr),
        .i_wr_data (w_flags_wdata),
        .i_rd_en   (i_cmd.rd),
        .i_rd_addr (r_pos),
        .o_rd_data (w_flags_rd)
    );

    // {value, key}; value is kept with the key, never returned
    lpht_ram #(
        .WIDTH (DW),
        .DEPTH (TABLE_SLOTS)
    ) u_data (
        .i_clk     (i_clk),
        .i_wr_en   (w_data_we),
        .i_wr_addr (r_pos),
        .i_wr_data ({r_value, r_key}),
        .i_rd_en   (i_cmd.rd),
        .i_rd_addr (r_pos),
        .o_rd_data (w_data_rd)
    );

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_key   <= w_clean;
            r_value <= i_value;
            r_hash  <= HASH_SEED;
            r_byte  <= 3'd0;
            r_rem   <= '0;
            r_mcnt  <= 2'd0;
        end
        if (i_cmd.hash_step) begin
            if (w_byte != 8'd0) r_hash <= w_hash_next;
            r_byte <= r_byte + 3'd1;
        end
        if (i_cmd.mod_step) begin
            r_quot <= w_prod[63:32];
            r_rem  <= w_diff[AW:0];
            r_mcnt <= r_mcnt + 2'd1;
            if (r_mcnt == 2'd2) begin
                r_pos    <= w_rem_fix[AW-1:0];
                r_probes <= '0;
            end
        end
        if (i_cmd.eval) begin
            if (w_done) begin
                r_res_status <= w_status;
                r_res_slot   <= (w_status == ST_OK) ? SLOT_W'(r_pos) : '0;
            end else begin
                r_pos    <= w_pos_next;
                r_probes <= r_probes + 1'b1;
            end
        end
        if (i_cmd.emit) begin
            r_out_status <= r_res_status;
            r_out_slot   <= r_res_slot;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_step) r_clr_addr <= r_clr_addr + 1'b1;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.clr_last  = (r_clr_addr == LAST);
    assign o_sts.hash_last = (w_byte == 8'd0) || (r_byte == 3'd7);
    assign o_sts.mod_last  = (r_mcnt == 2'd2);
    assign o_sts.eval_done = w_done;
    assign o_sts.out_busy  = r_out_valid && !i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_status;
    assign o_out_slot   = r_out_slot;

endmodule

`default_nettype wire

// File: sv/linear_probe_hash_table_top.sv
// Top level of the linear-probe hash table: stream ports, controller and
// datapath. Depends on lpht_pkg, lpht_ctrl, lpht_dp (and lpht_ram below it).
//
//  Channel  Dir  Handshake               tdata (low bit up)            tuser
//  -------  ---  ----------------------  ----------------------------  ------
//  s_axis   in   i_s_axis_tvalid/tready  key[63:0], stored_index[94:64] op
//  m_axis   out  o_m_axis_tvalid/tready  slot[7:0]                     status
//
//  Each word: accept, hash steps (key length + 1, at most 8), 3 remainder
//  steps, a read and a judgment per slot probed, then the handoff. The probe
//  loop is bound by the registered read of the slot tables: each slot
//  probed is read, then judged. After reset every entry of the flag table
//  is swept clear, while s_axis tready stays low. One word is in flight at
//  a time; the next is taken while a finished result waits in the output
//  register.
`default_nettype none

module linear_probe_hash_table_top #(
    parameter int TABLE_SLOTS = lpht_pkg::TABLE_SLOTS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // request
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    input  wire logic [lpht_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,  // key, stored_index
    input  wire logic                               i_s_axis_tuser,  // op
    // result
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    output logic      [lpht_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,  // slot
    output logic      [lpht_pkg::STATUS_W-1:0]      o_m_axis_tuser   // status
);
    import lpht_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    lpht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // tdata[95] is padding
    lpht_dp #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_op         (i_s_axis_tuser),
        .i_key        (i_s_axis_tdata[KEY_W-1:0]),
        .i_value      (i_s_axis_tdata[KEY_W +: VAL_W]),
        .i_out_ready  (i_m_axis_tready),
        .o_out_valid  (o_m_axis_tvalid),
        .o_out_status (o_m_axis_tuser),
        .o_out_slot   (o_m_axis_tdata)
    );

endmodule

`default_nettype wire

// File: sv/lpht_checker.sv
// Port-level checks for the hash table top, bound to it below.
// Depends on lpht_pkg and linear_probe_hash_table_top.
`default_nettype none

module lpht_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               i_s_tvalid,
    input wire logic                               i_s_tready,
    input wire logic                               i_m_tvalid,
    input wire logic                               i_m_tready,
    input wire logic [lpht_pkg::OUT_TDATA_W-1:0]   i_m_tdata,
    input wire logic [lpht_pkg::STATUS_W-1:0]      i_m_tuser
);
    import lpht_pkg::*;

    // reset clears the output and starts the clear sweep
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid && !i_s_tready)
        else $error("outputs not quiet after reset");

    // one request at a time
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && i_s_tready |=> !i_s_tready)
        else $error("second word taken while one is in flight");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> (i_m_tuser == ST_OK) || (i_m_tuser == ST_FULL)
                       || (i_m_tuser == ST_ABSENT))
        else $error("bad status code");

    a_fail_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && (i_m_tuser != ST_OK) |-> i_m_tdata == '0)
        else $error("nonzero slot on failure");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata)
                                      && $stable(i_m_tuser))
        else $error("result changed while stalled");

endmodule

bind linear_probe_hash_table_top lpht_checker u_lpht_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_axis_tvalid),
    .i_s_tready (o_s_axis_tready),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tdata  (o_m_axis_tdata),
    .i_m_tuser  (o_m_axis_tuser)
);

`default_nettype wire
